>>> hw/rtl/mtrd_pkg.sv
// shared constants, request and status codes, and scan control type
`timescale 1ns / 1ps

package mtrd_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int WORD_W        = 32;

  localparam logic [1:0] REQ_PUSH_FRONT   = 2'd0;
  localparam logic [1:0] REQ_PUSH_REAR    = 2'd1;
  localparam logic [1:0] REQ_REMOVE_FRONT = 2'd2;
  localparam logic [1:0] REQ_REMOVE_REAR  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic step;
    logic init;
  } mtrd_scan_ctl_t;

endpackage

>>> hw/rtl/mtrd_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module mtrd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/mtrd_min_unit.sv
// signed compare unit holding the running minimum during a rescan
`timescale 1ns / 1ps

module mtrd_min_unit
  import mtrd_pkg::*;
#(
  parameter int AW = 4
) (
  input  logic                     clk,
  input  mtrd_scan_ctl_t           ctl,
  input  logic signed [WORD_W-1:0] cand_val,
  input  logic [AW-1:0]            cand_slot,
  output logic signed [WORD_W-1:0] best_val,
  output logic [AW-1:0]            best_slot
);

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      if (ctl.init || (cand_val < best_val)) begin
        best_val  <= cand_val;
        best_slot <= cand_slot;
      end
    end
  end

endmodule

>>> hw/rtl/min_tracking_ring_deque.sv
// circular deque of signed words with tracking of the smallest entry
// push or failed request: done the cycle after start is taken
// removal reads the ram, then S_RD takes the word and raises done; removal of the minimum value adds a rescan
// rescan reads one entry a cycle through the single ram read port
// busy high while a removal runs; next request taken while done is high; no result stall
// rst (synchronous) empties the deque; entry contents stay undefined until written
`timescale 1ns / 1ps

module min_tracking_ring_deque
  import mtrd_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [1:0]                       req_type,
  input  logic signed [WORD_W-1:0]         value,
  output logic                             busy,
  output logic                             done,
  output logic [1:0]                       status,
  output logic signed [WORD_W-1:0]         removed_value,
  output logic [$clog2(DEPTH+1)-1:0]       entry_count,
  output logic [$clog2(DEPTH)-1:0]         min_position,
  output logic signed [WORD_W-1:0]         min_value
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_SCAN} state_t;

  state_t                     state;
  logic [AW-1:0]              front;
  logic [AW-1:0]              rear;
  logic [CW-1:0]              count;
  logic [AW-1:0]              min_slot;
  logic signed [WORD_W-1:0]   min_val;
  logic [AW-1:0]              iss_slot;
  logic [CW-1:0]              iss_left;
  logic [AW-1:0]              cmp_slot;
  logic                       dv;
  logic                       dv_first;

  logic                       is_push;
  logic [AW-1:0]              front_dec;
  logic [AW-1:0]              front_inc;
  logic [AW-1:0]              rear_dec;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [WORD_W-1:0]          rd_data;
  logic signed [WORD_W-1:0]   rd_val;
  mtrd_scan_ctl_t             scan_ctl;
  logic signed [WORD_W-1:0]   best_val;
  logic [AW-1:0]              best_slot;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
    return (s == '0) ? LAST_SLOT : s - 1'b1;
  endfunction

  assign is_push   = req_type inside {REQ_PUSH_FRONT, REQ_PUSH_REAR};
  assign front_dec = slot_dec(front);
  assign front_inc = slot_inc(front);
  assign rear_dec  = slot_dec(rear);
  assign rd_val    = $signed(rd_data);

  assign wr_en   = (state == S_IDLE) && start && is_push && (count != FULL_COUNT);
  assign wr_addr = (req_type == REQ_PUSH_FRONT) ? front_dec : rear;
  assign rd_en   = ((state == S_IDLE) && start && !is_push && (count != '0)) ||
                   ((state == S_SCAN) && (iss_left != '0));
  assign rd_addr = (state == S_SCAN) ? iss_slot :
                   ((req_type == REQ_REMOVE_FRONT) ? front : rear_dec);

  assign scan_ctl.step = dv;
  assign scan_ctl.init = dv_first;

  mtrd_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(value),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  mtrd_min_unit #(
    .AW(AW)
  ) u_min (
    .clk      (clk),
    .ctl      (scan_ctl),
    .cand_val (rd_val),
    .cand_slot(cmp_slot),
    .best_val (best_val),
    .best_slot(best_slot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      front    <= '0;
      rear     <= '0;
      count    <= '0;
      min_slot <= '0;
      done     <= 1'b0;
      dv       <= 1'b0;
      dv_first <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            removed_value <= '0;
            if (is_push) begin
              done <= 1'b1;
              if (count == FULL_COUNT) begin
                status <= ST_FULL;
              end else begin
                status <= ST_OK;
                count  <= count + 1'b1;
                if (req_type == REQ_PUSH_FRONT) begin
                  front <= front_dec;
                end else begin
                  rear <= slot_inc(rear);
                end
                if ((count == '0) || (value < min_val)) begin
                  min_slot <= wr_addr;
                  min_val  <= value;
                end
              end
            end else if (count == '0) begin
              status <= ST_EMPTY;
              done   <= 1'b1;
            end else begin
              count <= count - 1'b1;
              if (req_type == REQ_REMOVE_FRONT) begin
                front <= front_inc;
                if (count == CW'(1)) begin
                  min_slot <= front_inc;
                end
              end else begin
                rear <= rear_dec;
              end
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          removed_value <= rd_val;
          status        <= ST_OK;
          if ((count != '0) && (rd_val == min_val)) begin
            iss_slot <= front;
            iss_left <= count;
            dv       <= 1'b0;
            state    <= S_SCAN;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          dv <= (iss_left != '0);
          if (iss_left != '0) begin
            cmp_slot <= iss_slot;
            dv_first <= (iss_left == count);
            iss_slot <= slot_inc(iss_slot);
            iss_left <= iss_left - 1'b1;
          end else if (!dv) begin
            min_slot <= best_slot;
            min_val  <= best_val;
            done     <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state != S_IDLE);
  assign entry_count  = count;
  assign min_position = min_slot;
  assign min_value    = (count != '0) ? min_val : '0;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count beyond depth");

  a_push_ok: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && is_push && (count != FULL_COUNT))
      |=> (done && (status == ST_OK) && (count == $past(count) + 1'b1)))
    else $error("accepted push did not complete in one cycle");

  a_remove_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !is_push && (count != '0)) |=> (busy && !done))
    else $error("removal did not enter the read phase");

  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    busy |-> !wr_en)
    else $error("store written while a removal runs");

endmodule

>>> tb/min_tracking_ring_deque_tb.sv
// self-checking testbench for the minimum-tracking circular deque
`timescale 1ns / 1ps

module min_tracking_ring_deque_tb
  import mtrd_pkg::*;
;

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 24;

  typedef logic signed [WORD_W-1:0]      word_t;
  typedef logic [$clog2(DEPTH)-1:0]      slot_t;
  typedef logic [$clog2(DEPTH+1)-1:0]    count_t;

  typedef struct {
    logic [1:0] status;
    word_t      removed;
    count_t     count;
    slot_t      min_pos;
    word_t      min_val;
  } deque_result_t;

  logic   clk;
  logic   rst;
  logic   start;
  logic [1:0] req_type;
  word_t  value;
  logic   busy;
  logic   done;
  logic [1:0] status;
  word_t  removed_value;
  count_t entry_count;
  slot_t  min_position;
  word_t  min_value;

  // shadow copy of the deque
  word_t  shadow_store [DEPTH];
  slot_t  shadow_front;
  slot_t  shadow_rear;
  count_t shadow_count;
  slot_t  shadow_min;

  deque_result_t results_due [$];
  int mismatch_count = 0;
  int idle_pct = 0;
  int quiet_cycles = 0;

  min_tracking_ring_deque #(.DEPTH(DEPTH)) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .req_type      (req_type),
    .value         (value),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .removed_value (removed_value),
    .entry_count   (entry_count),
    .min_position  (min_position),
    .min_value     (min_value)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic slot_t next_slot(input slot_t s);
    return (s == slot_t'(DEPTH - 1)) ? slot_t'(0) : slot_t'(s + 1'b1);
  endfunction

  function automatic slot_t prev_slot(input slot_t s);
    return (s == slot_t'(0)) ? slot_t'(DEPTH - 1) : slot_t'(s - 1'b1);
  endfunction

  function automatic deque_result_t apply_request(input logic [1:0] req, input word_t val);
    deque_result_t r;
    slot_t slot;
    word_t best_val;
    int i;
    r.status  = ST_OK;
    r.removed = '0;
    if (req == REQ_PUSH_FRONT || req == REQ_PUSH_REAR) begin
      if (shadow_count == count_t'(DEPTH)) begin
        r.status = ST_FULL;
      end else begin
        shadow_count = shadow_count + 1'b1;
        if (req == REQ_PUSH_FRONT) begin
          shadow_front = prev_slot(shadow_front);
          slot = shadow_front;
        end else begin
          slot = shadow_rear;
          shadow_rear = next_slot(shadow_rear);
        end
        if (shadow_count == count_t'(1) || val < shadow_store[shadow_min])
          shadow_min = slot;
        shadow_store[slot] = val;
      end
    end else begin
      if (shadow_count == count_t'(0)) begin
        r.status = ST_EMPTY;
      end else begin
        shadow_count = shadow_count - 1'b1;
        if (req == REQ_REMOVE_FRONT) begin
          r.removed = shadow_store[shadow_front];
          shadow_front = next_slot(shadow_front);
          if (shadow_count == count_t'(0))
            shadow_min = shadow_front;
        end else begin
          shadow_rear = prev_slot(shadow_rear);
          r.removed = shadow_store[shadow_rear];
        end
        if (shadow_count != count_t'(0) && r.removed == shadow_store[shadow_min]) begin
          // rescan from front to rear, first strictly smallest wins
          slot = shadow_front;
          shadow_min = shadow_front;
          best_val = shadow_store[shadow_front];
          for (i = 1; i < shadow_count; i++) begin
            slot = next_slot(slot);
            if (shadow_store[slot] < best_val) begin
              best_val = shadow_store[slot];
              shadow_min = slot;
            end
          end
        end
      end
    end
    r.count   = shadow_count;
    r.min_pos = shadow_min;
    r.min_val = (shadow_count != count_t'(0)) ? shadow_store[shadow_min] : word_t'(0);
    return r;
  endfunction

  task automatic note_mismatch(input string field, input longint want, input longint got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    mismatch_count++;
  endtask

  task automatic send_request(input logic [1:0] req, input word_t val);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    req_type <= req;
    value    <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    results_due.push_back(apply_request(req, val));
  endtask

  function automatic word_t pick_value();
    case ($urandom_range(9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2, 3:    return word_t'($urandom);
      default: return word_t'(int'($urandom_range(8)) - 4);
    endcase
  endfunction

  task automatic test_empty_requests();
    send_request(REQ_REMOVE_FRONT, 32'sh0);
    send_request(REQ_REMOVE_REAR, 32'sh7fffffff);
  endtask

  task automatic test_single_entry();
    // front removal emptying the deque, then rear removal emptying it
    send_request(REQ_PUSH_REAR, 32'sd5);
    send_request(REQ_REMOVE_FRONT, 32'sh0);
    send_request(REQ_PUSH_FRONT, -32'sd7);
    send_request(REQ_REMOVE_REAR, 32'sh0);
  endtask

  task automatic test_full_store();
    word_t fill_words [16];
    int i;
    fill_words = '{32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sd1,
                   32'sh80000000, 32'sd1, 32'sh55555555, 32'shaaaaaaaa,
                   32'sh0, 32'sh80000000, 32'sd3, -32'sd2,
                   32'sh7fffffff, 32'sh00ff00ff, 32'shff00ff00, -32'sd1};
    for (i = 0; i < DEPTH; i++)
      send_request((i % 2 == 0) ? REQ_PUSH_REAR : REQ_PUSH_FRONT, fill_words[i % 16]);
    send_request(REQ_PUSH_FRONT, 32'sh80000000);
    send_request(REQ_PUSH_REAR, 32'sh7fffffff);
  endtask

  task automatic test_random(input int n);
    int push_pct;
    int run_left;
    int k;
    logic [1:0] req;
    run_left = 0;
    push_pct = 50;
    for (k = 0; k < n; k++) begin
      // runs biased to fill, to drain or neither, so both ends are reached often
      if (run_left == 0) begin
        run_left = $urandom_range(8, 40);
        case ($urandom_range(3))
          0:       push_pct = 85;
          1:       push_pct = 15;
          2:       push_pct = 50;
          default: push_pct = $urandom_range(100);
        endcase
      end
      run_left--;
      if ($urandom_range(99) < push_pct)
        req = $urandom_range(1) ? REQ_PUSH_REAR : REQ_PUSH_FRONT;
      else
        req = $urandom_range(1) ? REQ_REMOVE_REAR : REQ_REMOVE_FRONT;
      send_request(req, pick_value());
    end
  endtask

  always @(posedge clk) begin : check_results
    deque_result_t want;
    if (!rst && done) begin
      if (results_due.size() == 0) begin
        note_mismatch("unexpected result", 0, 0);
      end else begin
        want = results_due.pop_front();
        if (status !== want.status)
          note_mismatch("status", longint'(want.status), longint'(status));
        if (removed_value !== want.removed)
          note_mismatch("removed_value", longint'(want.removed), longint'(removed_value));
        if (entry_count !== want.count)
          note_mismatch("entry_count", longint'(want.count), longint'(entry_count));
        if (min_position !== want.min_pos)
          note_mismatch("min_position", longint'(want.min_pos), longint'(min_position));
        if (min_value !== want.min_val)
          note_mismatch("min_value", longint'(want.min_val), longint'(min_value));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("min_tracking_ring_deque_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (shadow_store[i]) shadow_store[i] = '0;
    shadow_front = '0;
    shadow_rear  = '0;
    shadow_count = '0;
    shadow_min   = '0;
    rst      = 1'b1;
    start    = 1'b0;
    req_type = REQ_PUSH_FRONT;
    value    = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 12;
    test_empty_requests();
    test_single_entry();
    test_full_store();
    test_random(633);
    idle_pct = 65;
    test_random(633);
    idle_pct = 0;
    test_random(634);
    start <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0)
      $display("min_tracking_ring_deque_tb: clean");
    else
      $display("min_tracking_ring_deque_tb: errors");
    $finish;
  end

endmodule
